>>> sv/ipv6ehw_pkg.sv
package ipv6ehw_pkg;

    localparam logic [7:0] TYPE_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] TYPE_TCP        = 8'd6;
    localparam logic [7:0] TYPE_UDP        = 8'd17;
    localparam logic [7:0] TYPE_ROUTING    = 8'd43;
    localparam logic [7:0] TYPE_FRAGMENT   = 8'd44;
    localparam logic [7:0] TYPE_ICMP       = 8'd58;
    localparam logic [7:0] TYPE_NONE       = 8'd59;
    localparam logic [7:0] TYPE_DEST       = 8'd60;

    localparam logic [2:0] KIND_HOP_BY_HOP = 3'd0;
    localparam logic [2:0] KIND_DEST       = 3'd1;
    localparam logic [2:0] KIND_ROUTING    = 3'd2;
    localparam logic [2:0] KIND_FRAGMENT   = 3'd3;
    localparam logic [2:0] KIND_UDP        = 3'd4;
    localparam logic [2:0] KIND_TCP        = 3'd5;
    localparam logic [2:0] KIND_ICMP       = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN    = 3'd7;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_IMPL  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [3:0] ICMP_BYTES_RESET = 4'd8;
    localparam logic [3:0] ICMP_BYTES_MIN   = 4'd4;
    localparam logic [3:0] ICMP_BYTES_MAX   = 4'd8;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] first_next_header;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  header_kind;
        logic [15:0] header_offset;
        logic [11:0] header_bytes;
        logic [7:0]  next_type;
        logic        chain_end;
        logic [1:0]  status;
    } t_out_item;

    // A byte after classification: the kind of the first header and the two
    // candidate lengths that this byte would give are worked out up front.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [2:0]  first_kind;
        logic        first_is_none;
        logic [11:0] ext_len;
        logic [5:0]  tcp_len;
    } t_class_item;

    function automatic logic [2:0] kind_of(input logic [7:0] t);
        logic [2:0] k;
        unique case (t)
            TYPE_HOP_BY_HOP: k = KIND_HOP_BY_HOP;
            TYPE_DEST:       k = KIND_DEST;
            TYPE_ROUTING:    k = KIND_ROUTING;
            TYPE_FRAGMENT:   k = KIND_FRAGMENT;
            TYPE_UDP:        k = KIND_UDP;
            TYPE_TCP:        k = KIND_TCP;
            TYPE_ICMP:       k = KIND_ICMP;
            default:         k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

>>> sv/ipv6ehw_front.sv
module ipv6ehw_front (
    input  logic                     i_in_valid,
    input  ipv6ehw_pkg::t_in_item    i_in_data,
    input  logic                     i_queue_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output ipv6ehw_pkg::t_class_item o_push_data
);
    import ipv6ehw_pkg::*;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_push_data.data_byte     = i_in_data.data_byte;
        o_push_data.first_byte    = i_in_data.first_byte;
        o_push_data.last_byte     = i_in_data.last_byte;
        o_push_data.first_kind    = kind_of(i_in_data.first_next_header);
        o_push_data.first_is_none = (i_in_data.first_next_header == TYPE_NONE);
        // Extension header length field counts 8-byte units beyond the first.
        o_push_data.ext_len       = {1'b0, i_in_data.data_byte, 3'b000} + 12'd8;
        // TCP data offset counts 4-byte words.
        o_push_data.tcp_len       = {i_in_data.data_byte[7:4], 2'b00};
    end

endmodule

>>> sv/ipv6ehw_queue.sv
module ipv6ehw_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  ipv6ehw_pkg::t_class_item i_push_data,
    output logic                     o_full,
    output logic                     o_pop_valid,
    output ipv6ehw_pkg::t_class_item o_pop_data,
    input  logic                     i_pop
);
    import ipv6ehw_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_class_item         r_entries [QUEUE_DEPTH];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     n_count;

    assign o_full      = (r_count == CntW'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_entries[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> sv/ipv6ehw_walk.sv
module ipv6ehw_walk #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_entry_valid,
    input  ipv6ehw_pkg::t_class_item i_entry,
    output logic                     o_pop,
    input  logic                     i_cfg_wr_en,
    input  logic [3:0]               i_cfg_wr_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output ipv6ehw_pkg::t_out_item   o_out_data
);
    import ipv6ehw_pkg::*;

    localparam logic [15:0] MaxOffset = 16'(MAX_PACKET_BYTES);

    logic [15:0] r_byte_offset, n_byte_offset;
    logic [2:0]  r_cur_kind,    n_cur_kind;
    logic [15:0] r_hdr_start,   n_hdr_start;
    logic [11:0] r_hdr_len,     n_hdr_len;
    logic [7:0]  r_cap_next,    n_cap_next;
    logic        r_done,        n_done;
    logic [3:0]  r_icmp_bytes;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [15:0] eff_offset;
    logic [2:0]  eff_kind;
    logic [15:0] eff_start;
    logic [11:0] eff_len;
    logic [7:0]  eff_cap;
    logic        eff_done;

    logic [11:0] icmp_len;
    logic [15:0] offset_adv;
    logic [15:0] pos;
    logic [16:0] pos_inc;
    logic [11:0] len_new;
    logic [7:0]  cap_new;
    logic [2:0]  cap_kind;
    logic        complete;
    logic        res_valid;
    t_out_item   res;

    function automatic logic [11:0] init_len(input logic [2:0] k, input logic [11:0] icmp);
        logic [11:0] len;
        len = '0;
        if (k == KIND_FRAGMENT || k == KIND_UDP) begin
            len = 12'd8;
        end else if (k == KIND_ICMP) begin
            len = icmp;
        end
        return len;
    endfunction

    assign o_pop       = i_entry_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_icmp_bytes < ICMP_BYTES_MIN) begin
            icmp_len = {8'd0, ICMP_BYTES_MIN};
        end else if (r_icmp_bytes > ICMP_BYTES_MAX) begin
            icmp_len = {8'd0, ICMP_BYTES_MAX};
        end else begin
            icmp_len = {8'd0, r_icmp_bytes};
        end
    end

    // A first byte restarts the walk before the byte itself is looked at.
    always_comb begin
        eff_offset = r_byte_offset;
        eff_kind   = r_cur_kind;
        eff_start  = r_hdr_start;
        eff_len    = r_hdr_len;
        eff_cap    = r_cap_next;
        eff_done   = r_done;
        if (i_entry.first_byte) begin
            eff_offset = '0;
            eff_kind   = i_entry.first_kind;
            eff_start  = '0;
            eff_len    = init_len(i_entry.first_kind, icmp_len);
            eff_cap    = TYPE_NONE;
            eff_done   = i_entry.first_is_none;
        end
    end

    assign offset_adv = (eff_offset < MaxOffset) ? eff_offset + 16'd1 : eff_offset;
    assign pos        = eff_offset - eff_start;
    assign pos_inc    = {1'b0, pos} + 17'd1;
    assign cap_kind   = kind_of(cap_new);

    always_comb begin
        len_new  = eff_len;
        cap_new  = eff_cap;
        complete = 1'b0;
        if (eff_kind <= KIND_FRAGMENT) begin
            if (pos == 16'd0) begin
                cap_new = i_entry.data_byte;
            end else if (pos == 16'd1 && eff_kind <= KIND_ROUTING) begin
                len_new = i_entry.ext_len;
            end
            complete = (len_new != '0) && (pos_inc >= {5'd0, len_new});
        end else if (eff_kind == KIND_TCP) begin
            if (pos == 16'd12) begin
                len_new  = {6'd0, i_entry.tcp_len};
                complete = (i_entry.tcp_len <= 6'd13);
            end else begin
                complete = (pos > 16'd12) && (pos_inc >= {5'd0, len_new});
            end
        end else begin
            complete = (len_new != '0) && (pos_inc >= {5'd0, len_new});
        end
    end

    always_comb begin
        n_byte_offset = eff_offset;
        n_cur_kind    = eff_kind;
        n_hdr_start   = eff_start;
        n_hdr_len     = eff_len;
        n_cap_next    = eff_cap;
        n_done        = eff_done;
        res_valid     = 1'b0;
        res           = '0;
        if (eff_done) begin
            n_byte_offset = offset_adv;
        end else if (eff_offset >= MaxOffset) begin
            res_valid = 1'b1;
            res = '{header_kind: eff_kind, header_offset: eff_start,
                    header_bytes: pos[11:0], next_type: TYPE_NONE,
                    chain_end: 1'b1, status: STATUS_TRUNCATED};
            n_done = 1'b1;
        end else if (eff_kind == KIND_UNKNOWN) begin
            res_valid = 1'b1;
            res = '{header_kind: KIND_UNKNOWN, header_offset: eff_start,
                    header_bytes: 12'd0, next_type: TYPE_NONE,
                    chain_end: 1'b1, status: STATUS_NOT_IMPL};
            n_done        = 1'b1;
            n_byte_offset = offset_adv;
        end else begin
            n_byte_offset = offset_adv;
            if (complete) begin
                res_valid = 1'b1;
                res = '{header_kind: eff_kind, header_offset: eff_start,
                        header_bytes: len_new, next_type: cap_new,
                        chain_end: (cap_kind == KIND_UNKNOWN), status: STATUS_OK};
                n_cur_kind  = cap_kind;
                n_hdr_start = eff_offset + 16'd1;
                n_hdr_len   = init_len(cap_kind, icmp_len);
                n_cap_next  = TYPE_NONE;
                n_done      = (cap_new == TYPE_NONE);
            end else begin
                n_hdr_len  = len_new;
                n_cap_next = cap_new;
                if (i_entry.last_byte) begin
                    res_valid = 1'b1;
                    res = '{header_kind: eff_kind, header_offset: eff_start,
                            header_bytes: pos_inc[11:0], next_type: TYPE_NONE,
                            chain_end: 1'b1, status: STATUS_TRUNCATED};
                end
            end
            if (i_entry.last_byte) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_cur_kind    <= KIND_UNKNOWN;
            r_hdr_start   <= '0;
            r_hdr_len     <= '0;
            r_cap_next    <= TYPE_NONE;
            r_done        <= 1'b1;
            r_icmp_bytes  <= ICMP_BYTES_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_icmp_bytes <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_byte_offset <= n_byte_offset;
                r_cur_kind    <= n_cur_kind;
                r_hdr_start   <= n_hdr_start;
                r_hdr_len     <= n_hdr_len;
                r_cap_next    <= n_cap_next;
                r_done        <= n_done;
                r_out_valid   <= res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_out <= res;
        end
    end

endmodule

>>> sv/ipv6_ext_header_walker.sv
// IPv6 extension header walker.
// Input channel: one packet byte per transaction on i_in_valid / o_in_stall, carrying
// first_byte (restarts the walk using first_next_header) and last_byte flags.
// Output channel: one transaction on o_out_valid / i_out_stall for each header that
// completes, for an unimplemented type, or for a packet that ends mid-header or at the size limit.
// Configuration: i_cfg_wr_en with i_cfg_wr_data sets the ICMP header size; write it
// only while no bytes are in flight.
// Throughput is one byte per cycle while the output is not stalled. A byte enters a
// four-entry queue when it is accepted; the walker then pops it and registers any
// result in the output register, where it is held until the receiver takes it.
// The walker's combinational offset/length compare sets this pace.
// When the receiver stalls, the output register holds its transaction and the
// walker stops taking bytes; the queue absorbs up to four more before o_in_stall
// rises. Reset (synchronous, active low) empties the queue, drops any pending result,
// sets the ICMP size to 8 and leaves the walker idle until the next first byte.
module ipv6_ext_header_walker #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ipv6ehw_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ipv6ehw_pkg::t_out_item o_out_data,
    input  logic                   i_cfg_wr_en,
    input  logic [3:0]             i_cfg_wr_data
);
    import ipv6ehw_pkg::*;

    logic        push;
    t_class_item push_data;
    logic        queue_full;
    logic        pop_valid;
    t_class_item pop_data;
    logic        pop;

    ipv6ehw_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    ipv6ehw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_data),
        .i_pop       (pop)
    );

    ipv6ehw_walk #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (pop_valid),
        .i_entry       (pop_data),
        .o_pop         (pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

>>> tb/testbench.sv
module testbench;
    import ipv6ehw_pkg::*;

    localparam int MAX_PKT       = 65535;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 370;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_wr_en = 1'b0;
    logic [3:0] i_cfg_wr_data = '0;

    // Walker state as the block should hold it.
    logic [3:0]  icmp_size = ICMP_BYTES_RESET;
    int unsigned walk_offset = 0;
    logic [7:0]  hdr_type = TYPE_NONE;
    logic [15:0] hdr_start = '0;
    int unsigned hdr_len = 0;
    logic [7:0]  hdr_next = TYPE_NONE;
    bit          walk_stopped = 1'b1;

    t_out_item   pending_headers[$];
    logic [7:0]  pkt_bytes[$];
    int          mismatches = 0;
    int          headers_seen = 0;
    int          live_items = 0;
    bit          calm = 1'b0;
    int unsigned stall_hold = 0;
    int unsigned stall_len;

    ipv6_ext_header_walker #(
        .MAX_PACKET_BYTES(MAX_PKT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [2:0] header_kind_for(input logic [7:0] t);
        case (t)
            TYPE_HOP_BY_HOP: return KIND_HOP_BY_HOP;
            TYPE_DEST:       return KIND_DEST;
            TYPE_ROUTING:    return KIND_ROUTING;
            TYPE_FRAGMENT:   return KIND_FRAGMENT;
            TYPE_UDP:        return KIND_UDP;
            TYPE_TCP:        return KIND_TCP;
            TYPE_ICMP:       return KIND_ICMP;
            default:         return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic int unsigned icmp_span();
        if (icmp_size < ICMP_BYTES_MIN) return ICMP_BYTES_MIN;
        if (icmp_size > ICMP_BYTES_MAX) return ICMP_BYTES_MAX;
        return icmp_size;
    endfunction

    function automatic t_out_item header_report(input logic [2:0] kind,
            input logic [15:0] start, input int unsigned count, input logic [7:0] follow,
            input logic chain_over, input logic [1:0] st);
        t_out_item r;
        r.header_kind   = kind;
        r.header_offset = start;
        r.header_bytes  = count[11:0];
        r.next_type     = follow;
        r.chain_end     = chain_over;
        r.status        = st;
        return r;
    endfunction

    function automatic void open_header(input logic [7:0] t, input int unsigned start);
        logic [2:0] k;
        k = header_kind_for(t);
        hdr_type  = t;
        hdr_start = start[15:0];
        hdr_next  = TYPE_NONE;
        hdr_len   = 0;
        if (k == KIND_FRAGMENT || k == KIND_UDP) begin
            hdr_len = 8;
        end else if (k == KIND_ICMP) begin
            hdr_len = icmp_span();
        end
        if (t == TYPE_NONE) walk_stopped = 1'b1;
    endfunction

    // Advances the walk by one byte; returns 1 when the byte completes or ends a header or meets an unknown type.
    function automatic bit walk_byte(input t_in_item b, output t_out_item rep);
        logic [2:0]  k;
        int unsigned pos;
        bit          done;
        bit          produced;
        done = 1'b0;
        produced = 1'b0;
        rep = '0;
        if (b.first_byte) begin
            walk_offset = 0;
            walk_stopped = 1'b0;
            open_header(b.first_next_header, 0);
        end
        if (walk_stopped) begin
            if (walk_offset < MAX_PKT) walk_offset++;
            return 1'b0;
        end
        k = header_kind_for(hdr_type);
        pos = (walk_offset - hdr_start) & 32'hFFFF;
        // Past the size limit the offset stops moving and the header counts as cut off.
        if (walk_offset >= MAX_PKT) begin
            rep = header_report(k, hdr_start, pos, TYPE_NONE, 1'b1, STATUS_TRUNCATED);
            walk_stopped = 1'b1;
            return 1'b1;
        end
        if (k == KIND_UNKNOWN) begin
            rep = header_report(KIND_UNKNOWN, hdr_start, 0, TYPE_NONE, 1'b1, STATUS_NOT_IMPL);
            walk_stopped = 1'b1;
            if (walk_offset < MAX_PKT) walk_offset++;
            return 1'b1;
        end
        if (k <= KIND_FRAGMENT) begin
            if (pos == 0) begin
                hdr_next = b.data_byte;
            end else if (pos == 1 && k != KIND_FRAGMENT) begin
                hdr_len = 8 * (32'(b.data_byte) + 1);
            end
            done = hdr_len != 0 && pos + 1 >= hdr_len;
        end else if (k == KIND_TCP) begin
            if (pos == 12) begin
                hdr_len = 4 * 32'(b.data_byte[7:4]);
                done = hdr_len <= 13;
            end else begin
                done = pos > 12 && pos + 1 >= hdr_len;
            end
        end else begin
            done = hdr_len != 0 && pos + 1 >= hdr_len;
        end
        if (done) begin
            rep = header_report(k, hdr_start, hdr_len, hdr_next,
                                header_kind_for(hdr_next) == KIND_UNKNOWN, STATUS_OK);
            produced = 1'b1;
            open_header(hdr_next, walk_offset + 1);
        end else if (b.last_byte) begin
            rep = header_report(k, hdr_start, pos + 1, TYPE_NONE, 1'b1, STATUS_TRUNCATED);
            produced = 1'b1;
        end
        if (b.last_byte) walk_stopped = 1'b1;
        if (walk_offset < MAX_PKT) walk_offset++;
        return produced;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, headers_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Receiver side: random stall bursts, none while traffic is calm.
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold != 0) begin
            stall_hold--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_hold = $urandom_range(0, 10);
        end else begin
            stall_len = pick_gap();
            if (stall_len != 0) begin
                i_out_stall <= 1'b1;
                stall_hold = stall_len - 1;
            end
        end
    end

    // Outputs are sampled on the falling edge, where they are stable.
    always @(negedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (pending_headers.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h", got));
            end else begin
                want = pending_headers.pop_front();
                check_field("header_kind", 16'(got.header_kind), 16'(want.header_kind));
                check_field("header_offset", got.header_offset, want.header_offset);
                check_field("header_bytes", 16'(got.header_bytes), 16'(want.header_bytes));
                check_field("next_type", 16'(got.next_type), 16'(want.next_type));
                check_field("chain_end", 16'(got.chain_end), 16'(want.chain_end));
                check_field("status", 16'(got.status), 16'(want.status));
            end
            headers_seen++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STUCK_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ipv6_ext_header_walker: mismatch");
        $finish;
    end

    task automatic send_byte(input t_in_item b);
        int unsigned gap;
        t_out_item   rep;
        bit          taken;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            if (taken) begin
                if (b.first_byte || !walk_stopped) live_items++;
                if (walk_byte(b, rep)) pending_headers.push_back(rep);
            end
            @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [7:0] data, input logic first,
                               input logic [7:0] first_type, input logic last);
        t_in_item b;
        b.data_byte = data;
        b.first_byte = first;
        b.first_next_header = first_type;
        b.last_byte = last;
        send_byte(b);
    endtask

    // Bytes with no result may still sit in the input queue, so settle before going on.
    task automatic drain_walker();
        i_in_valid <= 1'b0;
        while (pending_headers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_icmp_size(input logic [3:0] size);
        drain_walker();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        icmp_size = size;
    endtask

    function automatic void add_random_bytes(input int unsigned n);
        repeat (n) pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [7:0] random_unknown_type();
        logic [7:0] t;
        do begin
            t = 8'($urandom);
        end while (header_kind_for(t) != KIND_UNKNOWN || t == TYPE_NONE);
        return t;
    endfunction

    function automatic void add_header(input logic [7:0] t, input logic [7:0] follow);
        int unsigned r;
        int unsigned len;
        int unsigned nib;
        r = $urandom_range(0, 99);
        case (header_kind_for(t))
            KIND_HOP_BY_HOP, KIND_DEST, KIND_ROUTING: begin
                // Mostly short options; now and then a long one.
                len = r < 88 ? $urandom_range(0, 2) :
                      r < 99 ? $urandom_range(3, 20) : $urandom_range(21, 255);
                pkt_bytes.push_back(follow);
                pkt_bytes.push_back(8'(len));
                add_random_bytes(8 * (len + 1) - 2);
            end
            KIND_FRAGMENT: begin
                pkt_bytes.push_back(follow);
                add_random_bytes(7);
            end
            KIND_UDP:  add_random_bytes(8);
            KIND_ICMP: add_random_bytes(icmp_span());
            KIND_TCP: begin
                nib = r < 80 ? $urandom_range(5, 15) : $urandom_range(0, 4);
                add_random_bytes(12);
                pkt_bytes.push_back({nib[3:0], 4'($urandom)});
                if (4 * nib > 13) add_random_bytes(4 * nib - 13);
            end
            default: ;
        endcase
    endfunction

    task automatic send_packet();
        logic [7:0]  chain[$];
        int unsigned cut;
        bit          mark_last;
        t_in_item    b;
        pkt_bytes.delete();
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0:       chain.push_back(TYPE_HOP_BY_HOP);
                1:       chain.push_back(TYPE_DEST);
                2:       chain.push_back(TYPE_ROUTING);
                default: chain.push_back(TYPE_FRAGMENT);
            endcase
        end
        case ($urandom_range(0, 8))
            0, 1, 2: chain.push_back(TYPE_TCP);
            3, 4:    chain.push_back(TYPE_UDP);
            5, 6:    chain.push_back(TYPE_ICMP);
            7:       chain.push_back(TYPE_NONE);
            default: chain.push_back(random_unknown_type());
        endcase
        for (int i = 0; i < chain.size(); i++) begin
            add_header(chain[i], i + 1 < chain.size() ? chain[i + 1] : TYPE_NONE);
        end
        add_random_bytes($urandom_range(0, 6));
        if (pkt_bytes.size() == 0) add_random_bytes(1);
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
        mark_last = $urandom_range(0, 9) != 0;
        calm = $urandom_range(0, 6) == 0;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            b.data_byte = pkt_bytes[i];
            b.first_byte = i == 0;
            b.first_next_header = i == 0 ? chain[0] : 8'($urandom);
            b.last_byte = mark_last && i == pkt_bytes.size() - 1;
            send_byte(b);
        end
    endtask

    task automatic send_noise();
        t_in_item b;
        repeat ($urandom_range(1, 5)) begin
            b.data_byte = 8'($urandom);
            b.first_byte = $urandom_range(0, 3) == 0;
            b.first_next_header = 8'($urandom);
            b.last_byte = $urandom_range(0, 3) == 0;
            send_byte(b);
        end
    endtask

    task automatic test_idle_and_no_next_header();
        send_fields(8'hA5, 1'b0, 8'hFF, 1'b1);
        send_fields(8'h00, 1'b1, TYPE_NONE, 1'b0);
        send_fields(8'hFF, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_unknown_first_header();
        send_fields(8'hFF, 1'b1, 8'hFF, 1'b0);
        send_fields(8'h00, 1'b0, 8'hFF, 1'b1);
    endtask

    task automatic test_truncated_first_byte();
        send_fields(8'h3A, 1'b1, TYPE_HOP_BY_HOP, 1'b1);
    endtask

    // A data offset nibble of zero completes the TCP header on its byte 12.
    task automatic test_short_tcp_header();
        for (int i = 0; i < 12; i++) begin
            send_fields(i[0] ? 8'hFF : 8'h00, i == 0, TYPE_TCP, 1'b0);
        end
        send_fields(8'h0F, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_icmp_size_clamp();
        set_icmp_size(4'd0);
        for (int i = 0; i < 4; i++) begin
            send_fields(8'($urandom), i == 0, TYPE_ICMP, i == 3);
        end
    endtask

    task automatic test_random_traffic();
        logic [3:0] sizes[5];
        int         goal;
        sizes = '{4'd15, 4'd4, 4'd8, 4'($urandom), 4'd6};
        foreach (sizes[p]) begin
            set_icmp_size(sizes[p]);
            goal = live_items + PHASE_ITEMS;
            while (live_items < goal) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_packet();
                end
            end
            calm = 1'b0;
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_no_next_header();
        test_unknown_first_header();
        test_truncated_first_byte();
        test_short_tcp_header();
        test_icmp_size_clamp();
        test_random_traffic();
        drain_walker();
        if (mismatches == 0) begin
            $display("ipv6_ext_header_walker: match");
        end else begin
            $display("ipv6_ext_header_walker: mismatch");
        end
        $finish;
    end

endmodule
